/* rtl/tkst_pkg.sv */
// Shared types and constants for the top-k sorted score table.
package tkst_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SCORE_W     = 31;
    localparam int TAG_W       = 16;
    localparam int READ_W      = 4;
    localparam int POS_W       = 4;
    localparam int COUNT_W     = 5;

    typedef enum logic [1:0] {
        KIND_CHECK  = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_READ   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   name_tag;
        logic [READ_W-1:0]  read_index;
    } req_t;

    typedef struct packed {
        logic               qualifies;
        logic               inserted;
        logic [POS_W-1:0]   position;
        logic               entry_valid;
        logic [SCORE_W-1:0] entry_score;
        logic [TAG_W-1:0]   entry_tag;
        logic               entry_highlight;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic               valid;
        logic               highlight;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } slot_t;

    typedef struct packed {
        logic             qualifies;
        logic [IDX_W-1:0] position;
        slot_t            rd_slot;
    } chain_stat_t;

endpackage

/* rtl/top_k_sorted_score_table_unit.sv */
// Top-k sorted score table: request decode, entry count and result register.
// A result is registered; it becomes valid in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; all slots compare in parallel.
// A new request is accepted while a result waits, provided the result is taken that cycle.
// Reset clears slot valid and highlight flags, the entry count and the result valid flag.
// Slot scores and tags are not cleared; no clearing pass is needed after reset.
module top_k_sorted_score_table_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  tkst_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output tkst_pkg::rsp_t rsp
);
    import tkst_pkg::*;

    logic             accept;
    logic             ins_en;
    chain_stat_t      stat;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign ins_en    = accept && (req.kind == KIND_INSERT);

    tkst_chain u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .ins_en (ins_en),
        .req    (req),
        .stat   (stat)
    );

    always_comb
    begin
        fill_next = fill_reg;
        if (ins_en && stat.qualifies && (fill_reg != CNT_W'(TABLE_DEPTH)))
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        rsp_next             = '0;
        rsp_next.entry_count = COUNT_W'(fill_next);
        case (req.kind)
            KIND_CHECK:
            begin
                rsp_next.qualifies = stat.qualifies;
            end
            KIND_INSERT:
            begin
                if (stat.qualifies)
                begin
                    rsp_next.qualifies = 1'b1;
                    rsp_next.inserted  = 1'b1;
                    rsp_next.position  = POS_W'(stat.position);
                end
            end
            KIND_READ:
            begin
                rsp_next.entry_valid     = stat.rd_slot.valid;
                rsp_next.entry_score     = stat.rd_slot.score;
                rsp_next.entry_tag       = stat.rd_slot.tag;
                rsp_next.entry_highlight = stat.rd_slot.highlight;
            end
            default:
            begin
                rsp_next.qualifies = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg <= fill_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The entry count never exceeds the table depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // A placed entry always qualified.
    a_ins_qual: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.inserted |-> rsp_reg.qualifies)
        else $error("inserted without qualifies");

    // A qualifying insert request yields an inserted result next cycle.
    a_ins_result: assert property (@(posedge clk) disable iff (!rst_n)
        ins_en && stat.qualifies |=> rsp_valid_reg && rsp_reg.inserted)
        else $error("qualifying insert did not report placement");

    // The entry count moves only on an accepted insert.
    a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ins_en |=> $stable(fill_reg))
        else $error("entry count changed without an insert");

endmodule

/* rtl/tkst_cell.sv */
// One table slot: compares its score with the broadcast one and shifts on insert.
module tkst_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   ins_en,
    input  logic [tkst_pkg::SCORE_W-1:0] new_score,
    input  logic [tkst_pkg::TAG_W-1:0]   new_tag,
    input  logic                   left_take,
    input  tkst_pkg::slot_t        left_slot,
    output logic                   take,
    output tkst_pkg::slot_t        slot
);
    import tkst_pkg::*;

    logic               valid_reg, valid_next;
    logic               highlight_reg, highlight_next;
    logic [SCORE_W-1:0] score_reg, score_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic               load;

    // The new entry belongs at or before this slot when the slot is empty or lower.
    assign take = !valid_reg || (score_reg < new_score);
    assign load = ins_en && take;

    always_comb
    begin
        valid_next     = valid_reg;
        highlight_next = highlight_reg;
        score_next     = score_reg;
        tag_next       = tag_reg;
        if (load)
        begin
            if (left_take)
            begin
                valid_next     = left_slot.valid;
                highlight_next = left_slot.highlight;
                score_next     = left_slot.score;
                tag_next       = left_slot.tag;
            end
            else
            begin
                valid_next     = 1'b1;
                highlight_next = 1'b1;
                score_next     = new_score;
                tag_next       = new_tag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            highlight_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            highlight_reg <= highlight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        tag_reg   <= tag_next;
    end

    assign slot = '{valid: valid_reg, highlight: highlight_reg,
                    score: score_reg, tag: tag_reg};

endmodule

/* rtl/tkst_chain.sv */
// Row of table slots with the insert position encoder and the read selector.
module tkst_chain (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  ins_en,
    input  tkst_pkg::req_t        req,
    output tkst_pkg::chain_stat_t stat
);
    import tkst_pkg::*;

    slot_t                  slot [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] take;
    logic [TABLE_DEPTH-1:0] boundary;
    logic [TABLE_DEPTH-1:0] rd_sel;
    logic [IDX_W-1:0]       pos;
    slot_t                  rd_slot;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        logic  left_take;
        slot_t left_slot;

        if (g == 0)
        begin : g_head
            assign left_take   = 1'b0;
            assign left_slot   = '0;
            assign boundary[g] = take[g];
        end
        else
        begin : g_body
            assign left_take   = take[g-1];
            assign left_slot   = slot[g-1];
            assign boundary[g] = take[g] && !take[g-1];
        end

        if (g < (1 << READ_W))
        begin : g_rd
            assign rd_sel[g] = (req.read_index == READ_W'(g));
        end
        else
        begin : g_nord
            assign rd_sel[g] = 1'b0;
        end

        tkst_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ins_en    (ins_en),
            .new_score (req.score),
            .new_tag   (req.name_tag),
            .left_take (left_take),
            .left_slot (left_slot),
            .take      (take[g]),
            .slot      (slot[g])
        );
    end

    always_comb
    begin
        pos     = '0;
        rd_slot = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (boundary[i])
            begin
                pos = pos | IDX_W'(i);
            end
            if (rd_sel[i])
            begin
                rd_slot = rd_slot | slot[i];
            end
        end
    end

    assign stat.qualifies = take[TABLE_DEPTH-1];
    assign stat.position  = pos;
    assign stat.rd_slot   = rd_slot.valid ? rd_slot : '0;

endmodule

/* dv/top_k_sorted_score_table_unit_tb.sv */
// Self-checking testbench for the top-k sorted score table with a built-in predictor.
module top_k_sorted_score_table_unit_tb;

    import tkst_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
    localparam logic [TAG_W-1:0] TAG_MAX = {TAG_W{1'b1}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    logic [SCORE_W-1:0] table_score [TABLE_DEPTH];
    logic [TAG_W-1:0] table_tag [TABLE_DEPTH];
    logic table_highlight [TABLE_DEPTH];
    int table_fill = 0;

    rsp_t pending_results [$];
    int errors = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int entries_placed = 0;
    int hold_cycles = 0;
    bit quiet = 1'b0;

    top_k_sorted_score_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            table_score[i] = '0;
            table_tag[i] = '0;
            table_highlight[i] = 1'b0;
        end
    end

    function automatic rsp_t predict_table(req_t r);
        rsp_t res;
        bit fits;
        bit found;
        int pos;
        int last;
        int i;
        res = '0;
        fits = (table_fill < TABLE_DEPTH) || (r.score > table_score[TABLE_DEPTH-1]);
        case (r.kind)
            KIND_CHECK:
                res.qualifies = fits;
            KIND_INSERT:
                if (fits)
                begin
                    pos = table_fill;
                    found = 1'b0;
                    for (i = 0; i < table_fill; i++)
                    begin
                        if (!found && table_score[i] < r.score)
                        begin
                            pos = i;
                            found = 1'b1;
                        end
                    end
                    last = (table_fill < TABLE_DEPTH) ? table_fill : TABLE_DEPTH - 1;
                    for (i = last; i > pos; i--)
                    begin
                        table_score[i] = table_score[i-1];
                        table_tag[i] = table_tag[i-1];
                        table_highlight[i] = table_highlight[i-1];
                    end
                    table_score[pos] = r.score;
                    table_tag[pos] = r.name_tag;
                    table_highlight[pos] = 1'b1;
                    if (table_fill < TABLE_DEPTH)
                        table_fill++;
                    res.qualifies = 1'b1;
                    res.inserted = 1'b1;
                    res.position = pos[POS_W-1:0];
                end
            KIND_READ:
                if (r.read_index < table_fill)
                begin
                    res.entry_valid = 1'b1;
                    res.entry_score = table_score[r.read_index];
                    res.entry_tag = table_tag[r.read_index];
                    res.entry_highlight = table_highlight[r.read_index];
                end
            default:
                ;
        endcase
        res.entry_count = table_fill[COUNT_W-1:0];
        return res;
    endfunction

    function automatic req_t make_request(logic [1:0] kind, logic [SCORE_W-1:0] score,
                                          logic [TAG_W-1:0] tag, logic [READ_W-1:0] idx);
        req_t r;
        r.kind = kind;
        r.score = score;
        r.name_tag = tag;
        r.read_index = idx;
        return r;
    endfunction

    task automatic send_request(req_t r);
        rsp_t want;
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
        want = predict_table(r);
        pending_results = {pending_results, want};
        requests_sent++;
        if (want.inserted)
            entries_placed++;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic wait_until_drained();
        int guard;
        guard = 0;
        while (pending_results.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0h", $time, rsp);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("qualifies", 32'(want.qualifies), 32'(rsp.qualifies));
                check_field("inserted", 32'(want.inserted), 32'(rsp.inserted));
                check_field("position", 32'(want.position), 32'(rsp.position));
                check_field("entry_valid", 32'(want.entry_valid), 32'(rsp.entry_valid));
                check_field("entry_score", 32'(want.entry_score), 32'(rsp.entry_score));
                check_field("entry_tag", 32'(want.entry_tag), 32'(rsp.entry_tag));
                check_field("entry_highlight", 32'(want.entry_highlight),
                            32'(rsp.entry_highlight));
                check_field("entry_count", 32'(want.entry_count), 32'(rsp.entry_count));
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                rsp_ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                rsp_ready <= 1'b1;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    task automatic test_empty_table();
        send_request(make_request(KIND_READ, '0, '0, '0));
        send_request(make_request(KIND_READ, '0, '0, 4'd15));
        send_request(make_request(KIND_CHECK, '0, '0, '0));
        send_request(make_request(KIND_CHECK, SCORE_MAX, '0, '0));
        send_request(make_request(KIND_UNUSED, SCORE_MAX, TAG_MAX, 4'd15));
    endtask

    task automatic test_ordering_and_ties();
        send_request(make_request(KIND_INSERT, 31'd100, 16'h0001, '0));
        send_request(make_request(KIND_INSERT, 31'd100, 16'h0002, '0));
        send_request(make_request(KIND_INSERT, 31'd200, 16'h0003, '0));
        send_request(make_request(KIND_INSERT, '0, '0, '0));
        send_request(make_request(KIND_INSERT, SCORE_MAX, TAG_MAX, '0));
        send_request(make_request(KIND_READ, '0, '0, 4'd0));
        send_request(make_request(KIND_READ, '0, '0, 4'd3));
        send_request(make_request(KIND_READ, '0, '0, 4'd5));
    endtask

    task automatic test_full_table();
        for (int i = 0; i < 11; i++)
            send_request(make_request(KIND_INSERT, 31'(10 * i + 10), 16'(16'h0100 + i), '0));
        send_request(make_request(KIND_INSERT, '0, 16'h0aaa, '0));
        send_request(make_request(KIND_CHECK, '0, '0, '0));
        send_request(make_request(KIND_CHECK, 31'd1, '0, '0));
        send_request(make_request(KIND_INSERT, 31'd1, TAG_MAX, '0));
        send_request(make_request(KIND_INSERT, 31'd300, 16'h0bbb, '0));
        send_request(make_request(KIND_READ, '0, '0, 4'd15));
    endtask

    function automatic req_t random_request();
        req_t r;
        int pick;
        r.score = SCORE_W'($urandom);
        r.name_tag = TAG_W'($urandom);
        r.read_index = READ_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40)
            r.kind = KIND_INSERT;
        else if (pick < 70)
            r.kind = KIND_READ;
        else if (pick < 95)
            r.kind = KIND_CHECK;
        else
            r.kind = KIND_UNUSED;
        case ($urandom_range(0, 4))
            0: r.score = SCORE_W'($urandom_range(0, 31));
            1: r.score = table_score[$urandom_range(0, TABLE_DEPTH - 1)];
            2: r.score = table_score[TABLE_DEPTH-1] + 31'($urandom_range(0, 2)) - 31'd1;
            3: r.score = table_score[TABLE_DEPTH-1] + 31'($urandom_range(0, 1000));
            default: ;
        endcase
        return r;
    endfunction

    task automatic test_backpressure();
        hold_cycles = 60;
        for (int i = 0; i < 20; i++)
            send_request(random_request());
        while (hold_cycles != 0)
            @(posedge clk);
        req_valid <= 1'b0;
        wait_until_drained();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_request(random_request());
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_ordering_and_ties();
        test_full_table();
        test_backpressure();
        test_random(1450);
        quiet = 1'b1;
        test_random(400);
        req_valid <= 1'b0;
        wait_until_drained();
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived, expected none left, actual %0d",
                     $time, pending_results.size(), pending_results.size());
        end
        $display("Sent %0d requests, %0d results checked, %0d entries placed in the table.",
                 requests_sent, results_seen, entries_placed);
        $display("Covered empty, partly filled and full table, ties, drops and stalls.");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
